// File: design/ovn_pkg.sv
`default_nettype none
package ovn_pkg;

    localparam int COORD_W  = 32;
    localparam int FREQ_W   = 20;
    localparam int SEED_W   = 8;
    localparam int OCT_W    = 4;
    localparam int OUT_W    = 16;
    localparam int INT_BITS = 8;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 4;

    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(3277);
    localparam logic [OCT_W-1:0]  OCT_RESET  = OCT_W'(1);

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_SEED = 2'd0;
    localparam t_reg_idx REG_FREQ = 2'd1;
    localparam t_reg_idx REG_OCT  = 2'd2;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,
        8'd161, 8'd78,  8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254,
        8'd245, 8'd255, 8'd247, 8'd247, 8'd40,  8'd185, 8'd248, 8'd251,
        8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,  8'd36,  8'd1,
        8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
        8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174,
        8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
        8'd167, 8'd44,  8'd43,  8'd77,  8'd180, 8'd204, 8'd8,   8'd81,
        8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254, 8'd210, 8'd210,
        8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
        8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,
        8'd47,  8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
        8'd181, 8'd235, 8'd193, 8'd206, 8'd70,  8'd180, 8'd174, 8'd0,
        8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116, 8'd127, 8'd198,
        8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
        8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
        8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195,
        8'd38,  8'd58,  8'd65,  8'd207, 8'd215, 8'd253, 8'd65,  8'd85,
        8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,  8'd89,  8'd232,
        8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
        8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187,
        8'd234, 8'd177, 8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143,
        8'd97,  8'd53,  8'd145, 8'd135, 8'd19,  8'd103, 8'd13,  8'd90,
        8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247, 8'd33,  8'd39,
        8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
        8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158,
        8'd42,  8'd30,  8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135,
        8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21,  8'd233,
        8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128, 8'd211, 8'd118,
        8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
        8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250,
        8'd209, 8'd92,  8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
    };

endpackage
`default_nettype wire

// File: design/ovn_coord_if.sv
`default_nettype none
interface ovn_coord_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface
`default_nettype wire

// File: design/ovn_noise_if.sv
`default_nettype none
interface ovn_noise_if;
    logic        valid;
    logic        ready;
    logic [15:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

// File: design/ovn_octave_lane.sv
`default_nettype none
module ovn_octave_lane
    import ovn_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire                            i_clk,
    input  wire                            i_en,
    input  wire  [INT_BITS+FRAC_BITS-1:0]  i_x,
    input  wire  [INT_BITS+FRAC_BITS-1:0]  i_y,
    input  wire  [SEED_W-1:0]              i_seed,
    output logic [INT_BITS+FRAC_BITS-1:0]  o_val
);
    localparam int F  = FRAC_BITS;
    localparam int CW = INT_BITS + FRAC_BITS;
    localparam logic [F:0]   ONE   = (F+1)'(1) << F;
    localparam logic [F+1:0] THREE = (F+2)'(3) << F;

    // stage A: smoothstep square and slope, hash rows
    logic [2*F-1:0] w_sqx_full, w_sqy_full;
    logic [F+1:0]   w_tx, w_ty;
    logic [7:0]     w_ix, w_iy, w_ry0, w_ry1;
    logic [F-1:0]   r_sqx, r_sqy;
    logic [F+1:0]   r_tx, r_ty;
    logic [7:0]     r_ix, r_row0, r_row1;

    assign w_ix       = i_x[CW-1:F];
    assign w_iy       = i_y[CW-1:F];
    assign w_sqx_full = i_x[F-1:0] * i_x[F-1:0];
    assign w_sqy_full = i_y[F-1:0] * i_y[F-1:0];
    assign w_tx       = THREE - {1'b0, i_x[F-1:0], 1'b0};
    assign w_ty       = THREE - {1'b0, i_y[F-1:0], 1'b0};
    assign w_ry0      = w_iy + i_seed;
    assign w_ry1      = w_iy + i_seed + 8'd1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx  <= w_sqx_full[2*F-1:F];
            r_sqy  <= w_sqy_full[2*F-1:F];
            r_tx   <= w_tx;
            r_ty   <= w_ty;
            r_ix   <= w_ix;
            r_row0 <= PERM_ROM[w_ry0];
            r_row1 <= PERM_ROM[w_ry1];
        end
    end

    // stage B: weights and corner values
    logic [2*F+1:0] w_wx_full, w_wy_full;
    logic [7:0]     w_a00, w_a10, w_a01, w_a11;
    logic [F-1:0]   r_wx, r_wy_b;
    logic [7:0]     r_c00, r_c10, r_c01, r_c11;

    assign w_wx_full = r_sqx * r_tx;
    assign w_wy_full = r_sqy * r_ty;
    assign w_a00     = r_row0 + r_ix;
    assign w_a10     = r_row0 + r_ix + 8'd1;
    assign w_a01     = r_row1 + r_ix;
    assign w_a11     = r_row1 + r_ix + 8'd1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx   <= w_wx_full[2*F-1:F];
            r_wy_b <= w_wy_full[2*F-1:F];
            r_c00  <= PERM_ROM[w_a00];
            r_c10  <= PERM_ROM[w_a10];
            r_c01  <= PERM_ROM[w_a01];
            r_c11  <= PERM_ROM[w_a11];
        end
    end

    // stage C: blend along x
    logic [F:0]   w_omx;
    logic [CW:0]  w_lo_full, w_hi_full;
    logic [CW-1:0] r_lo, r_hi;
    logic [F-1:0]  r_wy_c;

    assign w_omx     = ONE - {1'b0, r_wx};
    assign w_lo_full = r_c00 * w_omx + r_c10 * r_wx;
    assign w_hi_full = r_c01 * w_omx + r_c11 * r_wx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo   <= w_lo_full[CW-1:0];
            r_hi   <= w_hi_full[CW-1:0];
            r_wy_c <= r_wy_b;
        end
    end

    // stage D: blend along y
    logic [F:0]    w_omy;
    logic [CW+F:0] w_v_full;
    logic [CW-1:0] r_val;

    assign w_omy    = ONE - {1'b0, r_wy_c};
    assign w_v_full = r_lo * w_omy + r_hi * r_wy_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= w_v_full[CW+F-1:F];
        end
    end

    assign o_val = r_val;
endmodule
`default_nettype wire

// File: design/ovn_divider.sv
`default_nettype none
module ovn_divider
    import ovn_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 8
) (
    input  wire               i_clk,
    input  wire               i_en,
    input  wire  [NUM_W-1:0]  i_num,
    input  wire  [DEN_W-1:0]  i_den,
    output logic [NUM_W-1:0]  o_quot
);
    // restoring division, one quotient bit per stage
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_q   [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [DEN_W-1:0] w_rem_p;
        logic [NUM_W-1:0] w_num_p;
        logic [NUM_W-1:0] w_q_p;
        logic [DEN_W:0]   w_trial;
        logic [DEN_W:0]   w_diff;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_rem_p = '0;
            assign w_num_p = i_num;
            assign w_q_p   = '0;
        end else begin : g_next
            assign w_rem_p = r_rem[k-1];
            assign w_num_p = r_num[k-1];
            assign w_q_p   = r_q[k-1];
        end

        assign w_trial = {w_rem_p, w_num_p[NUM_W-1]};
        assign w_ge    = w_trial >= {1'b0, i_den};
        assign w_diff  = w_trial - {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_num[k] <= w_num_p << 1;
                r_q[k]   <= {w_q_p[NUM_W-2:0], w_ge};
            end
        end
    end

    assign o_quot = r_q[NUM_W-1];
endmodule
`default_nettype wire

// File: design/octave_value_noise_2d_top.sv
// Fractal 2D value noise, one sample per coordinate pair.
// Input channel i_coord carries coord_x / coord_y in signed Q16.16; output
// channel o_noise carries noise_value in unsigned Q0.16. Both are
// valid/ready; an item moves when both are high.
// Registers over the APB port: seed offset (0x0), frequency Q4.16 (0x4),
// octave count (0x8). Write them only while no item is in flight.
// Every octave has its own lane, so the whole block is a fixed pipeline:
// one item enters per cycle while the output is not held off. The
// bit-per-stage divider by 2^octaves - 1 makes up most of the pipeline;
// the four-stage octave lanes come before it.
// When the receiver holds off ready with a result shown, the whole pipeline
// freezes and i_coord.ready drops until the result is taken; nothing is lost.
// Reset (synchronous, active low) empties the pipeline and loads seed 0,
// frequency 3277 and one octave.
`default_nettype none
module octave_value_noise_2d_top
    import ovn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    ovn_coord_if.sink            i_coord,
    ovn_noise_if.source          o_noise,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [PADDR_W-1:0]   paddr,
    input  wire  [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);
    localparam int CW  = INT_BITS + FRAC_BITS;
    localparam int SW  = CW + MAX_OCTAVES;
    localparam int DW  = $clog2(MAX_OCTAVES + 1);
    localparam int CMP_W = OCT_W + DW;
    localparam int LV  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int P   = 1 << LV;
    localparam int NV  = 8 + LV + SW;
    localparam int SCALE_SH = 32 - FRAC_BITS;
    localparam int OUT_SH   = FRAC_BITS - 8;

    // configuration
    logic [SEED_W-1:0] r_seed;
    logic [FREQ_W-1:0] r_freq;
    logic [OCT_W-1:0]  r_oct;
    t_reg_idx          w_idx;

    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_freq <= FREQ_RESET;
            r_oct  <= OCT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_SEED: r_seed <= pwdata[SEED_W-1:0];
                REG_FREQ: r_freq <= pwdata[FREQ_W-1:0];
                REG_OCT:  r_oct  <= pwdata[OCT_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SEED: prdata = PDATA_W'(r_seed);
            REG_FREQ: prdata = PDATA_W'(r_freq);
            REG_OCT:  prdata = PDATA_W'(r_oct);
            default:  prdata = '0;
        endcase
    end

    // octave depth clamp, denominator 2^depth - 1
    logic [DW-1:0]          w_depth;
    logic [DW-1:0]          w_nshift;
    logic [MAX_OCTAVES-1:0] w_denom;

    always_comb begin
        priority if (r_oct == '0) begin
            w_depth = DW'(1);
        end else if (CMP_W'(MAX_OCTAVES) < CMP_W'(r_oct)) begin
            w_depth = DW'(MAX_OCTAVES);
        end else begin
            w_depth = DW'(r_oct);
        end
    end

    assign w_nshift = DW'(MAX_OCTAVES) - w_depth;
    assign w_denom  = {MAX_OCTAVES{1'b1}} >> w_nshift;

    // pipeline control: everything moves together
    logic          w_en;
    logic          w_acc;
    logic [NV-1:0] r_vld;

    assign w_en          = !r_vld[NV-1] || o_noise.ready;
    assign w_acc         = i_coord.valid && w_en;
    assign i_coord.ready = w_en;
    assign o_noise.valid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], w_acc};
        end
    end

    // stage 1: magnitude
    logic [31:0] r_mag_x, r_mag_y;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag_x <= i_coord.coord_x[31] ? 32'(-i_coord.coord_x) : 32'(i_coord.coord_x);
            r_mag_y <= i_coord.coord_y[31] ? 32'(-i_coord.coord_y) : 32'(i_coord.coord_y);
        end
    end

    // stage 2: frequency scaling, wrap to 8 integer bits
    logic [31+FREQ_W:0] w_prod_x, w_prod_y;
    logic [CW-1:0]      r_xa, r_ya;

    assign w_prod_x = r_mag_x * r_freq;
    assign w_prod_y = r_mag_y * r_freq;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xa <= w_prod_x[SCALE_SH +: CW];
            r_ya <= w_prod_y[SCALE_SH +: CW];
        end
    end

    // octave lanes, stages 3 to 6
    logic [CW-1:0] w_lane_v [MAX_OCTAVES];
    logic [SW-1:0] w_leaf   [P];

    for (genvar i = 0; i < P; i++) begin : g_lane
        if (i < MAX_OCTAVES) begin : g_oct
            logic [CW-1:0] w_lx, w_ly;
            assign w_lx = CW'(r_xa << i);
            assign w_ly = CW'(r_ya << i);

            ovn_octave_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_x    (w_lx),
                .i_y    (w_ly),
                .i_seed (r_seed),
                .o_val  (w_lane_v[i])
            );

            // weight 2^(depth-1-i), scaled up by 2^(MAX-depth) until normalising
            assign w_leaf[i] = (DW'(i) < w_depth) ?
                               (SW'(w_lane_v[i]) << (MAX_OCTAVES - 1 - i)) : '0;
        end else begin : g_pad
            assign w_leaf[i] = '0;
        end
    end

    // registered adder tree
    logic [SW-1:0] r_tree [LV][P/2];

    for (genvar l = 0; l < LV; l++) begin : g_lvl
        for (genvar j = 0; j < (P >> (l + 1)); j++) begin : g_node
            if (l == 0) begin : g_leaf
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_tree[l][j] <= w_leaf[2*j] + w_leaf[2*j+1];
                    end
                end
            end else begin : g_inner
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_tree[l][j] <= r_tree[l-1][2*j] + r_tree[l-1][2*j+1];
                    end
                end
            end
        end
    end

    // normalise back to 2^(depth-1-i) weights
    logic [SW-1:0] r_norm;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_norm <= r_tree[LV-1][0] >> w_nshift;
        end
    end

    logic [SW-1:0] w_quot;

    ovn_divider #(
        .NUM_W (SW),
        .DEN_W (MAX_OCTAVES)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_norm),
        .i_den  (w_denom),
        .o_quot (w_quot)
    );

    logic [OUT_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_quot[OUT_SH +: OUT_W];
        end
    end

    assign o_noise.noise_value = r_out;

    // checks
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_vld[0])
        else $error("accepted item missing from first stage");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_denom_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_denom != '0)
        else $error("zero divisor");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_depth != '0 && w_depth <= DW'(MAX_OCTAVES))
        else $error("octave depth out of range");
endmodule
`default_nettype wire

// File: verif/ovn_noise_checker.sv
`default_nettype none
module ovn_noise_checker
    import ovn_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    ovn_coord_if               coord_bus,
    ovn_noise_if               noise_bus,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire                pready,
    input  wire  [PADDR_W-1:0] paddr,
    input  wire  [PDATA_W-1:0] pwdata,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int FB = 16;
    localparam longint unsigned ONE = 64'd1 << FB;
    localparam longint unsigned COORD_MASK = (64'd1 << (INT_BITS + FB)) - 1;

    logic [SEED_W-1:0] seed_q;
    logic [FREQ_W-1:0] freq_q;
    logic [OCT_W-1:0]  oct_q;
    logic [OUT_W-1:0]  noise_expected[$];
    int                mismatch_count;

    function automatic longint unsigned scaled_coord(logic [31:0] raw);
        logic [31:0] mag;
        mag = raw[31] ? (~raw + 32'd1) : raw;
        return ((longint'(mag) * longint'(freq_q)) >> (32 - FB)) & COORD_MASK;
    endfunction

    function automatic longint unsigned smoothstep_q(longint unsigned s);
        longint unsigned sq;
        sq = (s * s) >> FB;
        return (sq * (3 * ONE - 2 * s)) >> FB;
    endfunction

    function automatic longint unsigned lattice_hash(int unsigned xi, int unsigned yi);
        logic [7:0] row;
        logic [7:0] col;
        row = PERM_ROM[8'(yi + seed_q)];
        col = 8'(row + xi);
        return PERM_ROM[col];
    endfunction

    function automatic longint unsigned octave_sample(longint unsigned xa,
                                                      longint unsigned ya);
        int unsigned     xi, yi;
        longint unsigned wx, wy, lo, hi;
        xi = 32'((xa >> FB) & 255);
        yi = 32'((ya >> FB) & 255);
        wx = smoothstep_q(xa & (ONE - 1));
        wy = smoothstep_q(ya & (ONE - 1));
        lo = lattice_hash(xi, yi) * (ONE - wx) + lattice_hash(xi + 1, yi) * wx;
        hi = lattice_hash(xi, yi + 1) * (ONE - wx) + lattice_hash(xi + 1, yi + 1) * wx;
        return (lo * (ONE - wy) + hi * wy) >> FB;
    endfunction

    function automatic logic [OUT_W-1:0] fractal_noise(logic [31:0] cx, logic [31:0] cy);
        int unsigned     depth;
        longint unsigned xa, ya, acc, denom;
        depth = 32'(oct_q);
        if (depth == 0) depth = 1;
        if (depth > 8) depth = 8;
        xa  = scaled_coord(cx);
        ya  = scaled_coord(cy);
        acc = 0;
        for (int unsigned i = 0; i < depth; i++) begin
            acc += octave_sample(xa, ya) << (depth - 1 - i);
            xa = (xa << 1) & COORD_MASK;
            ya = (ya << 1) & COORD_MASK;
        end
        denom = (64'd1 << depth) - 1;
        return OUT_W'((acc / denom) >> (INT_BITS + FB - 16));
    endfunction

    assign o_pending = noise_expected.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_q         <= '0;
            freq_q         <= FREQ_RESET;
            oct_q          <= OCT_RESET;
            o_fail_count   <= 0;
            mismatch_count <= 0;
            noise_expected.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_SEED: seed_q <= pwdata[SEED_W-1:0];
                    REG_FREQ: freq_q <= pwdata[FREQ_W-1:0];
                    REG_OCT:  oct_q  <= pwdata[OCT_W-1:0];
                    default: ;
                endcase
            end
            if (coord_bus.valid && coord_bus.ready)
                noise_expected.push_back(fractal_noise(coord_bus.coord_x, coord_bus.coord_y));
            if (noise_bus.valid && noise_bus.ready) begin
                if (noise_expected.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected noise item %0h", noise_bus.noise_value);
                    mismatch_count <= mismatch_count + 1;
                end else if (noise_expected[0] !== noise_bus.noise_value) begin
                    o_fail_count <= o_fail_count + 1;
                    if (mismatch_count < 10)
                        $display("noise_value mismatch: expected %0h got %0h",
                                 noise_expected[0], noise_bus.noise_value);
                    mismatch_count <= mismatch_count + 1;
                    void'(noise_expected.pop_front());
                end else begin
                    void'(noise_expected.pop_front());
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: verif/octave_value_noise_2d_top_tb.sv
`default_nettype none
module octave_value_noise_2d_top_tb;
    import ovn_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count, pending;
    int                 tx_idle_pct, rx_idle_pct;
    int                 hold_cycles;

    ovn_coord_if coord_ch();
    ovn_noise_if noise_ch();

    octave_value_noise_2d_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coord (coord_ch),
        .o_noise (noise_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ovn_noise_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .coord_bus    (coord_ch),
        .noise_bus    (noise_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial begin
        noise_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                noise_ch.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                noise_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_coord(logic [31:0] cx, logic [31:0] cy);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            coord_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        coord_ch.valid   <= 1'b1;
        coord_ch.coord_x <= cx;
        coord_ch.coord_y <= cy;
        do @(posedge i_clk); while (!coord_ch.ready);
    endtask

    task automatic drain;
        int guard;
        @(negedge i_clk);
        coord_ch.valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        // mostly full range, some small coordinates near the lattice origin
        if ($urandom_range(0, 3) == 0)
            return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        return $urandom();
    endfunction

    logic [31:0] dir_vals[10] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                  32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000,
                                  32'h013F_FFFF, 32'h00FF_8000, 32'hA5A5_5A5A};
    logic [7:0]  seeds[6]  = '{8'd0, 8'd255, 8'd0, 8'd17, 8'd200, 8'd0};
    logic [19:0] freqs[6]  = '{20'd3277, 20'hFFFFF, 20'd1, 20'd0, 20'd65536, 20'd0};
    logic [3:0]  octs[6]   = '{4'd1, 4'd8, 4'd1, 4'd0, 4'd15, 4'd8};

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        coord_ch.valid   = 1'b0;
        coord_ch.coord_x = '0;
        coord_ch.coord_y = '0;
        tx_idle_pct      = 31;
        rx_idle_pct      = 87;
        hold_cycles      = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, then an edge-of-range setting
        for (int p = 0; p < 2; p++) begin
            if (p == 1) begin
                reg_write(REG_SEED, 32'(seeds[1]));
                reg_write(REG_FREQ, 32'(freqs[1]));
                reg_write(REG_OCT, 32'(octs[1]));
            end
            for (int i = 0; i < 10; i++)
                send_coord(dir_vals[i], dir_vals[9 - i]);
            drain();
        end

        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                tx_idle_pct = 31; rx_idle_pct = 87;
            end else if (ph < 4) begin
                tx_idle_pct = 87; rx_idle_pct = 31;
            end else begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            if (ph == 5) begin
                reg_write(REG_SEED, $urandom_range(0, 255));
                reg_write(REG_FREQ, $urandom_range(1, 20'hFFFFF));
                reg_write(REG_OCT, $urandom_range(1, 8));
            end else begin
                reg_write(REG_SEED, 32'(seeds[ph]));
                reg_write(REG_FREQ, 32'(freqs[(ph + 1) % 5]));
                reg_write(REG_OCT, 32'(octs[(ph + 2) % 5]));
            end
            for (int i = 0; i < 245; i++) begin
                if (ph == 4 && i == 20)
                    hold_cycles = 300;
                send_coord(rand_coord(), rand_coord());
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
design/ovn_pkg.sv
design/ovn_coord_if.sv
design/ovn_noise_if.sv
design/ovn_octave_lane.sv
design/ovn_divider.sv
design/octave_value_noise_2d_top.sv
verif/ovn_noise_checker.sv
verif/octave_value_noise_2d_top_tb.sv
